@@ hdl/hlq_pkg.sv @@
// ----------------------------------------------------------------------------
// hlq_pkg
// Shared types and constants for the hub-label distance query unit.
// ----------------------------------------------------------------------------
package hlq_pkg;

	localparam int LABEL_DEPTH = 64;
	localparam int IDX_W       = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
	localparam int CNT_W       = $clog2(LABEL_DEPTH + 1);
	localparam int HUB_W       = 32;
	localparam int COST_W      = 32;
	localparam int DIST_W      = COST_W + 1;

	localparam logic [DIST_W-1:0] INFINITY = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_LOAD_OUT = 2'd0,
		CMD_LOAD_IN  = 2'd1,
		CMD_QUERY    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} walk_state_t;

	typedef struct packed {
		logic              found;
		logic [HUB_W-1:0]  best_hub;
		logic [DIST_W-1:0] distance;
	} walk_result_t;

endpackage

@@ hdl/hub_label_distance_query_unit.sv @@
// ----------------------------------------------------------------------------
// hub_label_distance_query_unit
// Hub-label distance query: loads two sorted label lists, then merge-walks
// them and reports the least summed cost over the shared hubs.
// ----------------------------------------------------------------------------
// A load item gives no result; a load into a full list is dropped and flagged in
// the next result. After a query item is accepted, s_axis_tready stays low while
// the walk runs and until its result is taken into the output register, which
// then turns valid. The walk takes at most the sum of both list lengths minus one
// merge steps, one step per cycle through the single read port of each list
// memory. If the previous result still waits on the output, the query holds for
// as long as that result waits. Loads and queries are accepted again while a
// finished result still waits on the output. After each query both lists are
// empty again.
module hub_label_distance_query_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] hub, [63:32] cost
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [31:0] best_hub, [64:32] distance, [71:65] zero
	output logic [1:0]  m_axis_tuser   // [0] found, [1] overflow
);
	import hlq_pkg::*;

	logic              accept, load_out, load_in, start, clear;
	logic              out_full, in_full, idle, done, result_free;
	logic [CNT_W-1:0]  out_cnt, in_cnt;
	logic [IDX_W-1:0]  out_addr, in_addr;
	logic [HUB_W-1:0]  out_hub, in_hub;
	logic [COST_W-1:0] out_cost, in_cost;
	walk_result_t      result;
	cmd_t              cmd;
	logic              dropped_q, m_valid_q;
	walk_result_t      m_result_q;
	logic              m_overflow_q;

	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tuser);
	assign result_free   = !m_valid_q || m_axis_tready;
	assign clear         = done;

	always_comb begin
		load_out = 1'b0;
		load_in  = 1'b0;
		start    = 1'b0;
		case (cmd)
			CMD_LOAD_OUT: load_out = accept;
			CMD_LOAD_IN:  load_in  = accept;
			CMD_QUERY:    start    = accept;
			default: begin
			end
		endcase
	end

	hlq_label_list u_out_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_out),
		.wr_hub  (s_axis_tdata[31:0]),
		.wr_cost (s_axis_tdata[63:32]),
		.clear   (clear),
		.rd_addr (out_addr),
		.rd_hub  (out_hub),
		.rd_cost (out_cost),
		.count   (out_cnt),
		.full    (out_full)
	);

	hlq_label_list u_in_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_in),
		.wr_hub  (s_axis_tdata[31:0]),
		.wr_cost (s_axis_tdata[63:32]),
		.clear   (clear),
		.rd_addr (in_addr),
		.rd_hub  (in_hub),
		.rd_cost (in_cost),
		.count   (in_cnt),
		.full    (in_full)
	);

	hlq_merge_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.result_free (result_free),
		.out_cnt     (out_cnt),
		.in_cnt      (in_cnt),
		.out_hub     (out_hub),
		.out_cost    (out_cost),
		.in_hub      (in_hub),
		.in_cost     (in_cost),
		.out_addr    (out_addr),
		.in_addr     (in_addr),
		.idle        (idle),
		.done        (done),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (done) begin
			dropped_q <= 1'b0;
		end else if ((load_out && out_full) || (load_in && in_full)) begin
			dropped_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_result_q   <= result;
			m_overflow_q <= dropped_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_result_q.distance, m_result_q.best_hub};
	assign m_axis_tuser  = {m_overflow_q, m_result_q.found};

endmodule

@@ hdl/hlq_label_list.sv @@
// ----------------------------------------------------------------------------
// hlq_label_list
// One label list: hub and cost memories with one write and one registered
// read port, plus the fill count.
// ----------------------------------------------------------------------------
module hlq_label_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [hlq_pkg::HUB_W-1:0]  wr_hub,
	input  logic [hlq_pkg::COST_W-1:0] wr_cost,
	input  logic                       clear,
	input  logic [hlq_pkg::IDX_W-1:0]  rd_addr,
	output logic [hlq_pkg::HUB_W-1:0]  rd_hub,
	output logic [hlq_pkg::COST_W-1:0] rd_cost,
	output logic [hlq_pkg::CNT_W-1:0]  count,
	output logic                       full
);
	import hlq_pkg::*;

	logic [HUB_W-1:0]  hub_mem  [LABEL_DEPTH];
	logic [COST_W-1:0] cost_mem [LABEL_DEPTH];
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(LABEL_DEPTH));
	assign count = count_q;

	// Writes always land at the current fill position.
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			hub_mem[count_q[IDX_W-1:0]]  <= wr_hub;
			cost_mem[count_q[IDX_W-1:0]] <= wr_cost;
		end
		rd_hub  <= hub_mem[rd_addr];
		rd_cost <= cost_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (wr_en && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

endmodule

@@ hdl/hlq_merge_walk.sv @@
// ----------------------------------------------------------------------------
// hlq_merge_walk
// Merge walk over the two label lists, one step per cycle, keeping the
// least summed cost and its hub.
// ----------------------------------------------------------------------------
module hlq_merge_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       result_free,
	input  logic [hlq_pkg::CNT_W-1:0]  out_cnt,
	input  logic [hlq_pkg::CNT_W-1:0]  in_cnt,
	input  logic [hlq_pkg::HUB_W-1:0]  out_hub,
	input  logic [hlq_pkg::COST_W-1:0] out_cost,
	input  logic [hlq_pkg::HUB_W-1:0]  in_hub,
	input  logic [hlq_pkg::COST_W-1:0] in_cost,
	output logic [hlq_pkg::IDX_W-1:0]  out_addr,
	output logic [hlq_pkg::IDX_W-1:0]  in_addr,
	output logic                       idle,
	output logic                       done,
	output hlq_pkg::walk_result_t      result
);
	import hlq_pkg::*;

	walk_state_t      state_q, state_d;
	logic [CNT_W-1:0] a_q, b_q, a_n, b_n;
	walk_result_t     best_q;
	logic             active, lt, gt, eq;
	logic [DIST_W-1:0] sum;

	assign active = (a_q < out_cnt) && (b_q < in_cnt);
	assign lt     = out_hub < in_hub;
	assign gt     = out_hub > in_hub;
	assign eq     = !lt && !gt;
	assign sum    = {1'b0, out_cost} + {1'b0, in_cost};
	assign a_n    = a_q + CNT_W'(lt || eq);
	assign b_n    = b_q + CNT_W'(gt || eq);
	assign result = best_q;

	always_comb begin
		state_d  = state_q;
		out_addr = '0;
		in_addr  = '0;
		idle     = 1'b0;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				// The next positions are presented at once, so the memory data
				// for the following step is ready in the next cycle.
				if (active) begin
					out_addr = a_n[IDX_W-1:0];
					in_addr  = b_n[IDX_W-1:0];
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				done = result_free;
				if (result_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			best_q <= '{found: 1'b0, best_hub: '0, distance: INFINITY};
		end else if (state_q == ST_IDLE && start) begin
			a_q    <= '0;
			b_q    <= '0;
			best_q <= '{found: 1'b0, best_hub: '0, distance: INFINITY};
		end else if (state_q == ST_WALK && active) begin
			a_q <= a_n;
			b_q <= b_n;
			if (eq) begin
				best_q.found <= 1'b1;
				// Strict compare keeps the earliest shared hub on a tie.
				if (sum < best_q.distance) begin
					best_q.distance <= sum;
					best_q.best_hub <= out_hub;
				end
			end
		end
	end

endmodule

@@ tb/sv/hub_label_distance_query_unit_tb.sv @@
// ----------------------------------------------------------------------------
// hub_label_distance_query_unit_tb
// Streams label loads and queries into the hub-label distance query unit and
// checks every query answer against a predictor that keeps its own copy of
// both label lists, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module hub_label_distance_query_unit_tb;
	import hlq_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         RUN_ITEMS   = 1850;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         LONG_HOLD   = 600;
	localparam int         SETTLE      = 200;

	typedef struct {
		logic [1:0]        cmd;
		logic [HUB_W-1:0]  hub;
		logic [COST_W-1:0] cost;
		bit                pause;
	} label_item_t;

	typedef struct {
		logic              found;
		logic [HUB_W-1:0]  best_hub;
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} query_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // [31:0] hub, [63:32] cost
	logic [1:0]  s_axis_tuser = '0;   // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // [31:0] best_hub, [64:32] distance, [71:65] zero
	logic [1:0]  m_axis_tuser;        // [0] found, [1] overflow

	label_item_t   pending_q[$];
	query_answer_t answer_q[$];
	int            loaded_count = 0;
	int            fail_count = 0;
	int            taken_items = 0;
	int            cycle_count = 0;
	bit            taken_flag = 1'b0;

	// Predictor copy of the two label lists.
	logic [HUB_W-1:0]  src_hub[LABEL_DEPTH];
	logic [COST_W-1:0] src_cost[LABEL_DEPTH];
	logic [HUB_W-1:0]  dst_hub[LABEL_DEPTH];
	logic [COST_W-1:0] dst_cost[LABEL_DEPTH];
	int                src_count = 0;
	int                dst_count = 0;
	bit                lost_entry = 1'b0;

	// Sender state.
	bit drain_hold = 1'b0;
	int gap_left = 0;
	int burst_left = 8;

	// Receiver state.
	int hold_left = 0;
	bit hold_done = 1'b0;
	int rx_mode = 0;
	int rx_mode_left = 20;

	hub_label_distance_query_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string field, input logic [71:0] got,
			input logic [71:0] want);
		$display("ERROR at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
		fail_count++;
	endtask

	task automatic apply_label_item(input logic [1:0] cmd, input logic [HUB_W-1:0] hub,
			input logic [COST_W-1:0] cost);
		query_answer_t     ans;
		logic [DIST_W-1:0] sum;
		int                a;
		int                b;
		if (cmd == CMD_LOAD_OUT) begin
			if (src_count >= LABEL_DEPTH) begin
				lost_entry = 1'b1;
			end else begin
				src_hub[src_count]  = hub;
				src_cost[src_count] = cost;
				src_count++;
			end
		end else if (cmd == CMD_LOAD_IN) begin
			if (dst_count >= LABEL_DEPTH) begin
				lost_entry = 1'b1;
			end else begin
				dst_hub[dst_count]  = hub;
				dst_cost[dst_count] = cost;
				dst_count++;
			end
		end else if (cmd == CMD_QUERY) begin
			ans.found    = 1'b0;
			ans.best_hub = '0;
			ans.distance = INFINITY;
			ans.overflow = lost_entry;
			a = 0;
			b = 0;
			// Merge walk; the first shared hub wins on an equal sum.
			while (a < src_count && b < dst_count) begin
				if (src_hub[a] < dst_hub[b]) begin
					a++;
				end else if (src_hub[a] > dst_hub[b]) begin
					b++;
				end else begin
					sum = {1'b0, src_cost[a]} + {1'b0, dst_cost[b]};
					ans.found = 1'b1;
					if (sum < ans.distance) begin
						ans.distance = sum;
						ans.best_hub = src_hub[a];
					end
					a++;
					b++;
				end
			end
			answer_q.push_back(ans);
			src_count  = 0;
			dst_count  = 0;
			lost_entry = 1'b0;
		end
	endtask

	task automatic push_item(input logic [1:0] cmd, input logic [HUB_W-1:0] hub,
			input logic [COST_W-1:0] cost);
		label_item_t it;
		it.cmd   = cmd;
		it.hub   = hub;
		it.cost  = cost;
		it.pause = 1'b0;
		pending_q.push_back(it);
		if (cmd != CMD_UNUSED)
			loaded_count++;
	endtask

	task automatic push_pause();
		label_item_t it;
		it.cmd   = CMD_UNUSED;
		it.hub   = '0;
		it.cost  = '0;
		it.pause = 1'b1;
		pending_q.push_back(it);
	endtask

	function automatic logic [COST_W-1:0] pick_cost();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// One query set: two label lists loaded in interleaved order, then a query.
	task automatic gen_label_set(input bit big);
		longint unsigned src_h[$];
		longint unsigned dst_h[$];
		longint unsigned base;
		longint unsigned h;
		int              n_src;
		int              n_dst;
		int              i;
		int              j;
		bit              noisy;
		bit              pick_src;
		noisy = !big && ($urandom_range(0, 4) == 0);
		if (big) begin
			n_src = $urandom_range(56, LABEL_DEPTH + 3);
			n_dst = $urandom_range(56, LABEL_DEPTH + 3);
		end else if ($urandom_range(0, 15) == 0) begin
			n_src = $urandom_range(0, LABEL_DEPTH + 2);
			n_dst = $urandom_range(0, LABEL_DEPTH + 2);
		end else begin
			n_src = $urandom_range(0, 7);
			n_dst = $urandom_range(0, 7);
		end
		case ($urandom_range(0, 3))
			0: base = $urandom_range(0, 8);
			1: base = 64'hFFFF_FFF0 - $urandom_range(0, 64);
			default: base = $urandom;
		endcase
		h = base;
		for (i = 0; i < n_src && h <= 64'hFFFF_FFFF; i++) begin
			src_h.push_back(noisy ? longint'($urandom) : h);
			h += $urandom_range(1, 3);
		end
		h = base + $urandom_range(0, 3);
		for (i = 0; i < n_dst && h <= 64'hFFFF_FFFF; i++) begin
			dst_h.push_back(noisy ? longint'($urandom) : h);
			h += $urandom_range(1, 3);
		end
		i = 0;
		j = 0;
		while (i < src_h.size() || j < dst_h.size()) begin
			pick_src = (j >= dst_h.size()) ||
				(i < src_h.size() && $urandom_range(0, 1) == 0);
			if (pick_src) begin
				push_item(CMD_LOAD_OUT, src_h[i][31:0], pick_cost());
				i++;
			end else begin
				push_item(CMD_LOAD_IN, dst_h[j][31:0], pick_cost());
				j++;
			end
			if ($urandom_range(0, noisy ? 5 : 60) == 0)
				push_item(CMD_UNUSED, $urandom, $urandom);
		end
		push_item(CMD_QUERY, $urandom, $urandom);
	endtask

	// Driver: offers the next pending item at the falling edge.
	always @(negedge clk) begin
		label_item_t it;
		if (arst_n) begin
			if (s_axis_tvalid && !taken_flag) begin
				// Item still waiting for acceptance.
			end else if (drain_hold) begin
				s_axis_tvalid <= 1'b0;
				if (answer_q.size() == 0)
					drain_hold = 1'b0;
			end else if (gap_left > 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left--;
			end else if (pending_q.size() > 0) begin
				it = pending_q.pop_front();
				if (it.pause) begin
					s_axis_tvalid <= 1'b0;
					drain_hold = 1'b1;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {it.cost, it.hub};
					s_axis_tuser  <= it.cmd;
					burst_left--;
					if (burst_left <= 0) begin
						gap_left   = $urandom_range(1, 6);
						burst_left = ($urandom_range(0, 5) == 0) ?
							$urandom_range(40, 120) : $urandom_range(1, 12);
					end
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off mid run.
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && taken_items >= 900) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end else begin
				if (rx_mode_left <= 0) begin
					rx_mode      = $urandom_range(0, 2);
					rx_mode_left = $urandom_range(10, 80);
				end
				rx_mode_left--;
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					default: rdy = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
		m_axis_tready <= rdy;
	end

	// Monitor: results are checked before the same edge's input is predicted.
	always @(posedge clk) begin
		query_answer_t want;
		taken_flag <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (answer_q.size() == 0) begin
					flag_mismatch("unexpected result", m_axis_tdata, '0);
				end else begin
					want = answer_q.pop_front();
					if (m_axis_tuser[0] !== want.found)
						flag_mismatch("found", 72'(m_axis_tuser[0]), 72'(want.found));
					if (m_axis_tdata[31:0] !== want.best_hub)
						flag_mismatch("best_hub", 72'(m_axis_tdata[31:0]),
							72'(want.best_hub));
					if (m_axis_tdata[64:32] !== want.distance)
						flag_mismatch("distance", 72'(m_axis_tdata[64:32]),
							72'(want.distance));
					if (m_axis_tuser[1] !== want.overflow)
						flag_mismatch("overflow", 72'(m_axis_tuser[1]),
							72'(want.overflow));
					if (m_axis_tdata[71:65] !== 7'd0)
						flag_mismatch("tdata padding", 72'(m_axis_tdata[71:65]), '0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_label_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
				taken_items++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int set_idx;
		// Query on empty lists straight after reset.
		push_item(CMD_QUERY, '0, '0);
		// Largest costs on hub zero, with an unused command in between.
		push_item(CMD_LOAD_OUT, '0, '1);
		push_item(CMD_UNUSED, '1, '1);
		push_item(CMD_LOAD_IN, '0, '1);
		push_item(CMD_QUERY, '0, '0);
		// Three shared hubs with equal sums: the first one is kept.
		push_item(CMD_LOAD_OUT, 32'd5, 32'd10);
		push_item(CMD_LOAD_IN, 32'd5, 32'd0);
		push_item(CMD_LOAD_IN, 32'd6, 32'd1);
		push_item(CMD_LOAD_OUT, 32'd7, 32'd3);
		push_item(CMD_LOAD_IN, 32'd7, 32'd7);
		push_item(CMD_LOAD_OUT, 32'hFFFF_FFFF, 32'd0);
		push_item(CMD_LOAD_IN, 32'hFFFF_FFFF, 32'd10);
		push_item(CMD_QUERY, '1, '1);
		// Unsorted lists: the walk misses hub 2.
		push_item(CMD_LOAD_OUT, 32'd9, 32'd1);
		push_item(CMD_LOAD_OUT, 32'd2, 32'd1);
		push_item(CMD_LOAD_IN, 32'd2, 32'd1);
		push_item(CMD_LOAD_IN, 32'd9, 32'd4);
		push_item(CMD_QUERY, '0, '0);
		// One list empty.
		push_item(CMD_LOAD_OUT, 32'd1, 32'd1);
		push_item(CMD_QUERY, '0, '0);

		// The first two random sets are large and can overfill the lists.
		set_idx = 0;
		while (loaded_count < RUN_ITEMS) begin
			gen_label_set(set_idx < 2);
			if (set_idx == 20 || $urandom_range(0, 24) == 0)
				push_pause();
			set_idx++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 0 || s_axis_tvalid || drain_hold || answer_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/hlq_pkg.sv
hdl/hlq_label_list.sv
hdl/hlq_merge_walk.sv
hdl/hub_label_distance_query_unit.sv
tb/sv/hub_label_distance_query_unit_tb.sv
